[rtl/core/fowg_pkg.sv]
package fowg_pkg;

    localparam int TAG_ENTRIES     = 64;
    localparam int WARRANT_ENTRIES = 64;
    localparam int WATCH_ENTRIES   = 64;

    localparam int TAG_AW   = $clog2(TAG_ENTRIES > 1 ? TAG_ENTRIES : 2);
    localparam int WAR_AW   = $clog2(WARRANT_ENTRIES > 1 ? WARRANT_ENTRIES : 2);
    localparam int WCH_AW   = $clog2(WATCH_ENTRIES > 1 ? WATCH_ENTRIES : 2);

    localparam int TAG_DW = 128;   // key, value
    localparam int WAR_DW = 129;   // key, expiry, revoked
    localparam int WCH_DW = 96;    // device, inode

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_TIER     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_WATCH_ON = 1'd1;

    localparam logic [1:0] TIER_WARRANT = 2'd3;
    localparam logic [1:0] TIER_FILTER  = 2'd2;

    typedef enum logic [2:0] {
        REQ_CHECK     = 3'd0,
        REQ_SET_TAG   = 3'd1,
        REQ_CLR_TAG   = 3'd2,
        REQ_SET_WAR   = 3'd3,
        REQ_CLR_WAR   = 3'd4,
        REQ_ADD_WATCH = 3'd5,
        REQ_DEL_WATCH = 3'd6
    } req_t;

    localparam logic [2:0] DEC_PASS      = 3'd0;
    localparam logic [2:0] DEC_READ      = 3'd1;
    localparam logic [2:0] DEC_TAG_MISS  = 3'd2;
    localparam logic [2:0] DEC_TAG_HIT   = 3'd3;
    localparam logic [2:0] DEC_REVOKED   = 3'd4;
    localparam logic [2:0] DEC_EXPIRED   = 3'd5;
    localparam logic [2:0] DEC_WATCH_HIT = 3'd6;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;

    typedef enum logic [1:0] {
        TBL_TAG = 2'd0,
        TBL_WAR = 2'd1,
        TBL_WCH = 2'd2
    } tbl_t;

    // controller -> datapath
    typedef struct packed {
        logic       load;       // capture the input transaction
        logic       scan_start; // clear scan index and result flags
        logic       scan_step;  // issue next read / compare last one
        tbl_t       tbl;        // table under scan
        logic [1:0] key_sel;    // 0 request key, 1 tag value found
        logic       write_ent;  // write found/free slot of tbl
        logic       clear_ent;  // invalidate found slot of tbl
    } fowg_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic hit;
        logic free_ok;
        logic revoked;
        logic expired;
        logic is_write;
        req_t req;
    } fowg_sts_t;

    localparam logic [1:0] KEY_REQ = 2'd0;
    localparam logic [1:0] KEY_TAG = 2'd1;

endpackage

[rtl/core/fowg_ram.sv]
module fowg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/core/fowg_ctrl.sv]
module fowg_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  logic [1:0]          gate_tier,
    input  logic                read_watch_on,
    output logic [2:0]          decision,
    output logic [1:0]          update_status,
    output fowg_pkg::fowg_cmd_t cmd,
    input  fowg_pkg::fowg_sts_t sts
);
    import fowg_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_TAG_START, S_TAG_SCAN, S_WAR_START, S_WAR_SCAN,
        S_WCH_START, S_WCH_SCAN, S_UPDATE, S_OUT
    } state_t;

    state_t     state_reg;
    logic [2:0] dec_reg;
    logic [1:0] st_reg;
    logic       wch_hit_reg;

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = (state_reg == S_OUT);
    assign decision      = dec_reg;
    assign update_status = st_reg;

    always_comb
    begin
        cmd = '0;
        cmd.load = (state_reg == S_IDLE) && in_valid;
        case (state_reg)
            S_TAG_START: begin cmd.scan_start = 1'b1; cmd.tbl = TBL_TAG; end
            S_TAG_SCAN:  begin cmd.scan_step  = 1'b1; cmd.tbl = TBL_TAG; end
            S_WAR_START: begin cmd.scan_start = 1'b1; cmd.tbl = TBL_WAR; end
            S_WAR_SCAN:  begin cmd.scan_step  = 1'b1; cmd.tbl = TBL_WAR; end
            S_WCH_START: begin cmd.scan_start = 1'b1; cmd.tbl = TBL_WCH; end
            S_WCH_SCAN:  begin cmd.scan_step  = 1'b1; cmd.tbl = TBL_WCH; end
            S_UPDATE:
            begin
                case (sts.req)
                    REQ_SET_TAG, REQ_CLR_TAG:     cmd.tbl = TBL_TAG;
                    REQ_SET_WAR, REQ_CLR_WAR:     cmd.tbl = TBL_WAR;
                    default:                      cmd.tbl = TBL_WCH;
                endcase
                case (sts.req)
                    REQ_SET_TAG, REQ_SET_WAR:
                        cmd.write_ent = sts.hit || sts.free_ok;
                    REQ_ADD_WATCH:
                        cmd.write_ent = !sts.hit && sts.free_ok;
                    REQ_CLR_TAG, REQ_CLR_WAR, REQ_DEL_WATCH:
                        cmd.clear_ent = sts.hit;
                    default: ;
                endcase
            end
            default: ;
        endcase
        // warrant lookup after a check-open tag hit keys on the tag value
        cmd.key_sel = (sts.req == REQ_CHECK) ? KEY_TAG : KEY_REQ;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            dec_reg     <= DEC_PASS;
            st_reg      <= ST_DONE;
            wch_hit_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                    if (in_valid)
                    begin
                        state_reg <= S_DISPATCH;
                    end
                S_DISPATCH:
                begin
                    dec_reg <= DEC_PASS;
                    st_reg  <= ST_DONE;
                    case (sts.req)
                        REQ_CHECK:
                            if (gate_tier < TIER_FILTER)
                                state_reg <= S_OUT;
                            else if (!sts.is_write)
                            begin
                                dec_reg <= DEC_READ;
                                if (gate_tier == TIER_WARRANT && read_watch_on)
                                    state_reg <= S_WCH_START;
                                else
                                    state_reg <= S_OUT;
                            end
                            else if (gate_tier != TIER_WARRANT)
                                state_reg <= S_OUT;
                            else
                                state_reg <= S_TAG_START;
                        REQ_SET_TAG, REQ_CLR_TAG:     state_reg <= S_TAG_START;
                        REQ_SET_WAR, REQ_CLR_WAR:     state_reg <= S_WAR_START;
                        REQ_ADD_WATCH, REQ_DEL_WATCH: state_reg <= S_WCH_START;
                        default:                      state_reg <= S_OUT;
                    endcase
                end
                S_TAG_START: state_reg <= S_TAG_SCAN;
                S_WAR_START: state_reg <= S_WAR_SCAN;
                S_WCH_START: state_reg <= S_WCH_SCAN;
                S_TAG_SCAN:
                    if (sts.scan_done)
                    begin
                        if (sts.req != REQ_CHECK)
                            state_reg <= S_UPDATE;
                        else if (!sts.hit)
                        begin
                            if (sts.is_write) dec_reg <= DEC_TAG_MISS;
                            state_reg <= S_OUT;
                        end
                        else
                            state_reg <= S_WAR_START;
                    end
                S_WAR_SCAN:
                    if (sts.scan_done)
                    begin
                        if (sts.req != REQ_CHECK)
                            state_reg <= S_UPDATE;
                        else
                        begin
                            state_reg <= S_OUT;
                            if (!sts.is_write)
                            begin
                                if (sts.hit && wch_hit_reg) dec_reg <= DEC_WATCH_HIT;
                            end
                            else if (!sts.hit)
                                dec_reg <= DEC_TAG_MISS;
                            else if (sts.revoked)
                                dec_reg <= DEC_REVOKED;
                            else if (sts.expired)
                                dec_reg <= DEC_EXPIRED;
                            else
                                dec_reg <= DEC_TAG_HIT;
                        end
                    end
                S_WCH_SCAN:
                    if (sts.scan_done)
                    begin
                        wch_hit_reg <= sts.hit;
                        if (sts.req != REQ_CHECK)
                            state_reg <= S_UPDATE;
                        else if (sts.hit)
                            state_reg <= S_TAG_START;
                        else
                            state_reg <= S_OUT;
                    end
                S_UPDATE:
                begin
                    state_reg <= S_OUT;
                    case (sts.req)
                        REQ_SET_TAG, REQ_SET_WAR, REQ_ADD_WATCH:
                            if (!sts.hit && !sts.free_ok) st_reg <= ST_FULL;
                        REQ_CLR_TAG, REQ_CLR_WAR, REQ_DEL_WATCH:
                            if (!sts.hit) st_reg <= ST_ABSENT;
                        default: ;
                    endcase
                end
                S_OUT:
                    if (!out_stall)
                    begin
                        state_reg <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(decision)
                                      && $stable(update_status)))
        else $error("result changed under stall");
    a_update_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPDATE) |=> (decision == DEC_PASS))
        else $error("table request gave a decision");
    a_single_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.write_ent && cmd.clear_ent))
        else $error("write and clear together");
endmodule

[rtl/core/fowg_dp.sv]
module fowg_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [2:0]          req_type,
    input  logic                is_write,
    input  logic [63:0]         cgroup_id,
    input  logic [31:0]         device_number,
    input  logic [63:0]         inode_number,
    input  logic [63:0]         now_ns,
    input  logic [63:0]         warrant_id,
    input  logic [63:0]         expiry_ns,
    input  logic                revoked_flag,
    input  fowg_pkg::fowg_cmd_t cmd,
    output fowg_pkg::fowg_sts_t sts
);
    import fowg_pkg::*;

    localparam int IW = (TAG_AW > WAR_AW) ? ((TAG_AW > WCH_AW) ? TAG_AW : WCH_AW)
                                          : ((WAR_AW > WCH_AW) ? WAR_AW : WCH_AW);

    logic [2:0]  req_reg;
    logic        wr_reg;
    logic [63:0] cg_reg, ino_reg, now_reg, wid_reg, exp_reg;
    logic [31:0] dev_reg;
    logic        rev_reg;

    logic [TAG_ENTRIES-1:0]     tag_vld_reg;
    logic [WARRANT_ENTRIES-1:0] war_vld_reg;
    logic [WATCH_ENTRIES-1:0]   wch_vld_reg;

    // scan index counts one past depth; pending marks a read in flight
    logic [IW:0]   idx_reg;
    logic [IW-1:0] cmp_idx_reg;
    logic          pend_reg;
    logic          hit_reg, free_ok_reg, done_reg;
    logic [IW-1:0] hit_idx_reg, free_idx_reg;
    logic [63:0]   tag_val_reg;
    logic          found_rev_reg;
    logic [63:0]   found_exp_reg;

    logic [TAG_DW-1:0] tag_rd;
    logic [WAR_DW-1:0] war_rd;
    logic [WCH_DW-1:0] wch_rd;

    logic [IW:0]   depth;
    logic          cur_vld, cur_match;
    logic [63:0]   key;
    logic [IW-1:0] wr_idx;

    always_comb
    begin
        case (cmd.tbl)
            TBL_TAG: depth = (IW+1)'(TAG_ENTRIES);
            TBL_WAR: depth = (IW+1)'(WARRANT_ENTRIES);
            default: depth = (IW+1)'(WATCH_ENTRIES);
        endcase
        key = (cmd.key_sel == KEY_TAG) ? tag_val_reg : wid_reg;
        case (cmd.tbl)
            TBL_TAG:
            begin
                cur_vld   = tag_vld_reg[cmp_idx_reg[TAG_AW-1:0]];
                cur_match = tag_rd[127:64] == cg_reg;
            end
            TBL_WAR:
            begin
                cur_vld   = war_vld_reg[cmp_idx_reg[WAR_AW-1:0]];
                cur_match = war_rd[128:65] == key;
            end
            default:
            begin
                cur_vld   = wch_vld_reg[cmp_idx_reg[WCH_AW-1:0]];
                cur_match = (wch_rd[95:64] == dev_reg) && (wch_rd[63:0] == ino_reg);
            end
        endcase
        wr_idx = hit_reg ? hit_idx_reg : free_idx_reg;
    end

    fowg_ram #(.WIDTH(TAG_DW), .DEPTH(TAG_ENTRIES)) u_tag_ram (
        .clk   (clk),
        .we    (cmd.write_ent && cmd.tbl == TBL_TAG),
        .waddr (wr_idx[TAG_AW-1:0]),
        .wdata ({cg_reg, wid_reg}),
        .raddr (idx_reg[TAG_AW-1:0]),
        .rdata (tag_rd)
    );

    fowg_ram #(.WIDTH(WAR_DW), .DEPTH(WARRANT_ENTRIES)) u_war_ram (
        .clk   (clk),
        .we    (cmd.write_ent && cmd.tbl == TBL_WAR),
        .waddr (wr_idx[WAR_AW-1:0]),
        .wdata ({wid_reg, exp_reg, rev_reg}),
        .raddr (idx_reg[WAR_AW-1:0]),
        .rdata (war_rd)
    );

    fowg_ram #(.WIDTH(WCH_DW), .DEPTH(WATCH_ENTRIES)) u_wch_ram (
        .clk   (clk),
        .we    (cmd.write_ent && cmd.tbl == TBL_WCH),
        .waddr (wr_idx[WCH_AW-1:0]),
        .wdata ({dev_reg, ino_reg}),
        .raddr (idx_reg[WCH_AW-1:0]),
        .rdata (wch_rd)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req_type;
            wr_reg  <= is_write;
            cg_reg  <= cgroup_id;
            dev_reg <= device_number;
            ino_reg <= inode_number;
            now_reg <= now_ns;
            wid_reg <= warrant_id;
            exp_reg <= expiry_ns;
            rev_reg <= revoked_flag;
        end
        if (cmd.scan_step && pend_reg && !hit_reg && cur_vld && cur_match)
        begin
            hit_idx_reg   <= cmp_idx_reg;
            tag_val_reg   <= tag_rd[63:0];
            found_rev_reg <= war_rd[0];
            found_exp_reg <= war_rd[64:1];
        end
        if (cmd.scan_step && pend_reg && !free_ok_reg && !cur_vld)
        begin
            free_idx_reg <= cmp_idx_reg;
        end
        if (cmd.scan_step)
        begin
            cmp_idx_reg <= idx_reg[IW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_vld_reg <= '0;
            war_vld_reg <= '0;
            wch_vld_reg <= '0;
            idx_reg     <= '0;
            pend_reg    <= 1'b0;
            hit_reg     <= 1'b0;
            free_ok_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.scan_start)
            begin
                idx_reg     <= '0;
                pend_reg    <= 1'b0;
                hit_reg     <= 1'b0;
                free_ok_reg <= 1'b0;
                done_reg    <= 1'b0;
            end
            else if (cmd.scan_step && !done_reg)
            begin
                if (pend_reg)
                begin
                    if (cur_vld && cur_match) hit_reg <= 1'b1;
                    if (!cur_vld) free_ok_reg <= 1'b1;
                end
                // stop on first match, otherwise sweep the whole table
                if ((pend_reg && cur_vld && cur_match) || idx_reg == depth)
                begin
                    done_reg <= 1'b1;
                    pend_reg <= 1'b0;
                end
                else
                begin
                    pend_reg <= 1'b1;
                    idx_reg  <= idx_reg + 1'b1;
                end
            end
            if (cmd.write_ent)
            begin
                case (cmd.tbl)
                    TBL_TAG: tag_vld_reg[wr_idx[TAG_AW-1:0]] <= 1'b1;
                    TBL_WAR: war_vld_reg[wr_idx[WAR_AW-1:0]] <= 1'b1;
                    default: wch_vld_reg[wr_idx[WCH_AW-1:0]] <= 1'b1;
                endcase
            end
            if (cmd.clear_ent)
            begin
                case (cmd.tbl)
                    TBL_TAG: tag_vld_reg[hit_idx_reg[TAG_AW-1:0]] <= 1'b0;
                    TBL_WAR: war_vld_reg[hit_idx_reg[WAR_AW-1:0]] <= 1'b0;
                    default: wch_vld_reg[hit_idx_reg[WCH_AW-1:0]] <= 1'b0;
                endcase
            end
        end
    end

    assign sts.scan_done = done_reg;
    assign sts.hit       = hit_reg;
    assign sts.free_ok   = free_ok_reg;
    assign sts.revoked   = found_rev_reg;
    assign sts.expired   = now_reg > found_exp_reg;
    assign sts.is_write  = wr_reg;
    assign sts.req       = req_t'(req_reg);

    a_hit_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan_step && hit_reg) |=> hit_reg)
        else $error("hit lost during scan");
    a_done_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (idx_reg <= depth))
        else $error("scan ran past table");
    a_write_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_ent |-> (hit_reg || free_ok_reg))
        else $error("write with no slot");
endmodule

[rtl/core/file_open_warrant_gate.sv]
// Channel | Valid     | Stall     | Payload
// in      | in_valid  | in_stall  | req_type .. revoked_flag
// out     | out_valid | out_stall | decision, update_status
// cfg     | cfg_we    | -         | cfg_index, cfg_data
// One transaction at a time; each table scan reads through the registered
// RAM read port, stopping early on a match.
// A check open scans up to three tables; a table request scans one.
// rst_n clears control and valid bits at once; no clearing pass.
// The result holds while out_stall is high; input waits until it is taken.
module file_open_warrant_gate (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [2:0]                     req_type,
    input  logic                           is_write,
    input  logic [63:0]                    cgroup_id,
    input  logic [31:0]                    device_number,
    input  logic [63:0]                    inode_number,
    input  logic [63:0]                    now_ns,
    input  logic [63:0]                    warrant_id,
    input  logic [63:0]                    expiry_ns,
    input  logic                           revoked_flag,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [2:0]                     decision,
    output logic [1:0]                     update_status,
    input  logic                           cfg_we,
    input  logic [fowg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fowg_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fowg_pkg::*;

    logic [1:0] tier_reg;
    logic       rwatch_reg;
    fowg_cmd_t  cmd;
    fowg_sts_t  sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tier_reg   <= TIER_WARRANT;
            rwatch_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GATE_TIER:     tier_reg   <= cfg_data;
                CFG_READ_WATCH_ON: rwatch_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    fowg_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .gate_tier     (tier_reg),
        .read_watch_on (rwatch_reg),
        .decision      (decision),
        .update_status (update_status),
        .cmd           (cmd),
        .sts           (sts)
    );

    fowg_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_type      (req_type),
        .is_write      (is_write),
        .cgroup_id     (cgroup_id),
        .device_number (device_number),
        .inode_number  (inode_number),
        .now_ns        (now_ns),
        .warrant_id    (warrant_id),
        .expiry_ns     (expiry_ns),
        .revoked_flag  (revoked_flag),
        .cmd           (cmd),
        .sts           (sts)
    );
endmodule

[test/tb.sv]
`timescale 1ns / 100ps

module tb;
    import fowg_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        logic [2:0]  req;
        logic        wr;
        logic [63:0] cg;
        logic [31:0] dev;
        logic [63:0] ino;
        logic [63:0] now;
        logic [63:0] wid;
        logic [63:0] expiry;
        logic        rev;
    } open_req_t;

    typedef struct {
        logic [2:0] dec;
        logic [1:0] st;
    } verdict_t;

    // Gate predictor plus the queue of verdicts it still owes.
    class gate_board;
        logic [1:0]  tier;
        logic        watch_reads;
        logic [63:0] tag_key [TAG_ENTRIES];
        logic [63:0] tag_val [TAG_ENTRIES];
        bit          tag_ok  [TAG_ENTRIES];
        logic [63:0] war_key [WARRANT_ENTRIES];
        logic [63:0] war_exp [WARRANT_ENTRIES];
        bit          war_rev [WARRANT_ENTRIES];
        bit          war_ok  [WARRANT_ENTRIES];
        logic [31:0] wch_dev [WATCH_ENTRIES];
        logic [63:0] wch_ino [WATCH_ENTRIES];
        bit          wch_ok  [WATCH_ENTRIES];
        verdict_t    owed[$];
        int          errors;

        function new();
            tier = 2'd3;
            watch_reads = 1'b0;
            errors = 0;
            foreach (tag_ok[i]) tag_ok[i] = 0;
            foreach (war_ok[i]) war_ok[i] = 0;
            foreach (wch_ok[i]) wch_ok[i] = 0;
        endfunction

        function int tag_slot(logic [63:0] k);
            foreach (tag_ok[i]) if (tag_ok[i] && tag_key[i] == k) return i;
            return -1;
        endfunction

        function int war_slot(logic [63:0] k);
            foreach (war_ok[i]) if (war_ok[i] && war_key[i] == k) return i;
            return -1;
        endfunction

        function int wch_slot(logic [31:0] d, logic [63:0] n);
            foreach (wch_ok[i])
                if (wch_ok[i] && wch_dev[i] == d && wch_ino[i] == n) return i;
            return -1;
        endfunction

        function int held_warrant(logic [63:0] cg);
            int t;
            t = tag_slot(cg);
            if (t < 0) return -1;
            return war_slot(tag_val[t]);
        endfunction

        function logic [2:0] classify(open_req_t r);
            int w;
            if (tier < TIER_FILTER) return DEC_PASS;
            if (!r.wr)
            begin
                if (tier == TIER_WARRANT && watch_reads && wch_slot(r.dev, r.ino) >= 0
                    && held_warrant(r.cg) >= 0)
                    return DEC_WATCH_HIT;
                return DEC_READ;
            end
            if (tier < TIER_WARRANT) return DEC_PASS;
            w = held_warrant(r.cg);
            if (w < 0) return DEC_TAG_MISS;
            if (war_rev[w]) return DEC_REVOKED;
            if (r.now > war_exp[w]) return DEC_EXPIRED;
            return DEC_TAG_HIT;
        endfunction

        function void note(open_req_t r);
            verdict_t v;
            int i;
            v.dec = DEC_PASS;
            v.st = ST_DONE;
            case (r.req)
                REQ_CHECK: v.dec = classify(r);
                REQ_SET_TAG:
                begin
                    i = tag_slot(r.cg);
                    if (i < 0) foreach (tag_ok[j]) if (i < 0 && !tag_ok[j]) i = j;
                    if (i < 0) v.st = ST_FULL;
                    else
                    begin
                        tag_key[i] = r.cg;
                        tag_val[i] = r.wid;
                        tag_ok[i] = 1;
                    end
                end
                REQ_CLR_TAG:
                begin
                    i = tag_slot(r.cg);
                    if (i < 0) v.st = ST_ABSENT;
                    else tag_ok[i] = 0;
                end
                REQ_SET_WAR:
                begin
                    i = war_slot(r.wid);
                    if (i < 0) foreach (war_ok[j]) if (i < 0 && !war_ok[j]) i = j;
                    if (i < 0) v.st = ST_FULL;
                    else
                    begin
                        war_key[i] = r.wid;
                        war_exp[i] = r.expiry;
                        war_rev[i] = r.rev;
                        war_ok[i] = 1;
                    end
                end
                REQ_CLR_WAR:
                begin
                    i = war_slot(r.wid);
                    if (i < 0) v.st = ST_ABSENT;
                    else war_ok[i] = 0;
                end
                REQ_ADD_WATCH:
                begin
                    if (wch_slot(r.dev, r.ino) < 0)
                    begin
                        i = -1;
                        foreach (wch_ok[j]) if (i < 0 && !wch_ok[j]) i = j;
                        if (i < 0) v.st = ST_FULL;
                        else
                        begin
                            wch_dev[i] = r.dev;
                            wch_ino[i] = r.ino;
                            wch_ok[i] = 1;
                        end
                    end
                end
                REQ_DEL_WATCH:
                begin
                    i = wch_slot(r.dev, r.ino);
                    if (i < 0) v.st = ST_ABSENT;
                    else wch_ok[i] = 0;
                end
                default: ;
            endcase
            owed.push_back(v);
        endfunction

        function void check(logic [2:0] dec, logic [1:0] st);
            verdict_t v;
            if (owed.size() == 0)
            begin
                $display("%0t: unexpected result decision=%0d status=%0d", $time, dec, st);
                errors++;
                return;
            end
            v = owed.pop_front();
            if (dec !== v.dec)
            begin
                $display("%0t: decision expected %0d actual %0d", $time, v.dec, dec);
                errors++;
            end
            if (st !== v.st)
            begin
                $display("%0t: update_status expected %0d actual %0d", $time, v.st, st);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  req_type;
    logic        is_write;
    logic [63:0] cgroup_id;
    logic [31:0] device_number;
    logic [63:0] inode_number;
    logic [63:0] now_ns;
    logic [63:0] warrant_id;
    logic [63:0] expiry_ns;
    logic        revoked_flag;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  decision;
    logic [1:0]  update_status;
    logic        cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    gate_board board;
    int  idle_cycles;
    bit  stall_quiet;
    logic [63:0] cg_pool [8];
    logic [63:0] wid_pool [8];
    logic [31:0] dev_pool [4];
    logic [63:0] ino_pool [8];

    file_open_warrant_gate u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int gap_len();
        if ($urandom_range(9) < 6) return 0;
        if ($urandom_range(9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Result side: random stall, check at the accepting edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check(decision, update_status);
    end

    initial
    begin
        int n;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_quiet) out_stall <= 1'b0;
            else
            begin
                n = gap_len();
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(negedge clk);
                end
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog on handshake inactivity.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("** file_open_warrant_gate: FAILED **");
                $finish;
            end
        end
    end

    // Valid stays high between back-to-back transactions; drop it only for a gap.
    task automatic send(open_req_t r);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_type      <= r.req;
        is_write      <= r.wr;
        cgroup_id     <= r.cg;
        device_number <= r.dev;
        inode_number  <= r.ino;
        now_ns        <= r.now;
        warrant_id    <= r.wid;
        expiry_ns     <= r.expiry;
        revoked_flag  <= r.rev;
        in_valid      <= 1'b1;
        do @(posedge clk); while (in_stall);
        board.note(r);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.owed.size() != 0) @(posedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_GATE_TIER) board.tier = val;
        else board.watch_reads = val[0];
    endtask

    function automatic open_req_t make(logic [2:0] req, logic wr, logic [63:0] cg,
                                       logic [31:0] dev, logic [63:0] ino,
                                       logic [63:0] now, logic [63:0] wid,
                                       logic [63:0] expiry, logic rev);
        open_req_t r;
        r.req = req; r.wr = wr; r.cg = cg; r.dev = dev; r.ino = ino;
        r.now = now; r.wid = wid; r.expiry = expiry; r.rev = rev;
        return r;
    endfunction

    function automatic open_req_t pooled();
        open_req_t r;
        int k;
        k = $urandom_range(99);
        r = make(REQ_CHECK, 1'($urandom_range(1)), cg_pool[$urandom_range(7)],
                 dev_pool[$urandom_range(3)], ino_pool[$urandom_range(7)], rand64(),
                 wid_pool[$urandom_range(7)], rand64(), 1'($urandom_range(1)));
        if (k < 50) r.req = REQ_CHECK;
        else if (k < 60) r.req = REQ_SET_TAG;
        else if (k < 66) r.req = REQ_CLR_TAG;
        else if (k < 76) r.req = REQ_SET_WAR;
        else if (k < 82) r.req = REQ_CLR_WAR;
        else if (k < 90) r.req = REQ_ADD_WATCH;
        else if (k < 95) r.req = REQ_DEL_WATCH;
        else if (k < 97) r.req = 3'd7;
        else
        begin
            r.cg = rand64(); r.wid = rand64(); r.dev = $urandom; r.ino = rand64();
            r.req = 3'($urandom_range(6));
        end
        // Keep expiry near now to exercise the strict comparison.
        if ($urandom_range(2) == 0) r.now = r.expiry + 64'($urandom_range(2)) - 64'd1;
        return r;
    endfunction

    initial
    begin
        logic [63:0] ones;
        board = new();
        ones = '1;
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = '0; is_write = 1'b0; cgroup_id = '0; device_number = '0;
        inode_number = '0; now_ns = '0; warrant_id = '0; expiry_ns = '0;
        revoked_flag = 1'b0;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        stall_quiet = 0;
        idle_cycles = 0;
        foreach (cg_pool[i]) cg_pool[i] = rand64();
        foreach (wid_pool[i]) wid_pool[i] = rand64();
        foreach (dev_pool[i]) dev_pool[i] = $urandom;
        foreach (ino_pool[i]) ino_pool[i] = rand64();
        cg_pool[0] = '0; cg_pool[1] = ones; wid_pool[0] = '0; wid_pool[1] = ones;
        dev_pool[0] = '0; dev_pool[1] = '1; ino_pool[0] = '0; ino_pool[1] = ones;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset tier 3, misses, hit, revoked, expiry edges, watch.
        send(make(REQ_CHECK, 1, ones, '1, ones, ones, ones, ones, 1));
        send(make(REQ_CLR_TAG, 0, ones, 0, 0, 0, 0, 0, 0));
        send(make(REQ_CLR_WAR, 0, 0, 0, 0, 0, ones, 0, 0));
        send(make(REQ_DEL_WATCH, 0, 0, '1, ones, 0, 0, 0, 0));
        send(make(REQ_SET_TAG, 0, ones, 0, 0, 0, ones, 0, 0));
        send(make(REQ_CHECK, 1, ones, 0, 0, 0, 0, 0, 0));
        send(make(REQ_SET_WAR, 0, 0, 0, 0, 0, ones, 64'd100, 0));
        send(make(REQ_CHECK, 1, ones, 0, 0, 64'd100, 0, 0, 0));
        send(make(REQ_CHECK, 1, ones, 0, 0, 64'd101, 0, 0, 0));
        send(make(REQ_SET_WAR, 0, 0, 0, 0, 0, ones, ones, 1));
        send(make(REQ_CHECK, 1, ones, 0, 0, ones, 0, 0, 0));
        send(make(REQ_ADD_WATCH, 0, 0, '1, ones, 0, 0, 0, 0));
        send(make(REQ_ADD_WATCH, 0, 0, '1, ones, 0, 0, 0, 0));
        send(make(REQ_CHECK, 0, ones, '1, ones, 0, 0, 0, 0));
        send(make(3'd7, 1, ones, '1, ones, ones, ones, ones, 1));
        drain();
        write_reg(CFG_READ_WATCH_ON, 2'd1);
        send(make(REQ_CHECK, 0, ones, '1, ones, 0, 0, 0, 0));
        send(make(REQ_CHECK, 0, 0, '1, ones, 0, 0, 0, 0));
        drain();
        write_reg(CFG_GATE_TIER, 2'd2);
        send(make(REQ_CHECK, 0, ones, '1, ones, 0, 0, 0, 0));
        send(make(REQ_CHECK, 1, ones, 0, 0, 0, 0, 0, 0));
        drain();
        write_reg(CFG_GATE_TIER, 2'd0);
        send(make(REQ_CHECK, 1, ones, 0, 0, 0, 0, 0, 0));
        drain();
        write_reg(CFG_GATE_TIER, 2'd1);
        send(make(REQ_CHECK, 0, ones, '1, ones, 0, 0, 0, 0));
        drain();

        // Fill the tag, warrant and watch tables to overflow, then empty them.
        write_reg(CFG_GATE_TIER, 2'd3);
        stall_quiet = 1;
        for (int i = 0; i <= TAG_ENTRIES; i++)
            send(make(REQ_SET_TAG, 0, 64'(i) + 64'h1000, 0, 0, 0, rand64(), 0, 0));
        for (int i = 0; i <= WARRANT_ENTRIES; i++)
            send(make(REQ_SET_WAR, 0, 0, 0, 0, 0, 64'(i) + 64'h2000, rand64(), 0));
        for (int i = 0; i <= WATCH_ENTRIES; i++)
            send(make(REQ_ADD_WATCH, 0, 0, 32'(i), 64'(i), 0, 0, 0, 0));
        for (int i = 0; i < TAG_ENTRIES; i++)
            send(make(REQ_CLR_TAG, 0, 64'(i) + 64'h1000, 0, 0, 0, 0, 0, 0));
        for (int i = 0; i < WARRANT_ENTRIES; i++)
            send(make(REQ_CLR_WAR, 0, 0, 0, 0, 0, 64'(i) + 64'h2000, 0, 0));
        for (int i = 0; i < WATCH_ENTRIES; i++)
            send(make(REQ_DEL_WATCH, 0, 0, 32'(i), 64'(i), 0, 0, 0, 0));
        stall_quiet = 0;
        drain();

        // Random phases over pooled keys, each with its own settings.
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(CFG_GATE_TIER, (ph < 3) ? 2'd3 : 2'($urandom_range(3)));
            write_reg(CFG_READ_WATCH_ON, 2'($urandom_range(1)));
            stall_quiet = (ph == 2);
            for (int i = 0; i < 134; i++) send(pooled());
            drain();
        end

        if (board.errors == 0 && board.owed.size() == 0)
            $display("** file_open_warrant_gate: PASSED **");
        else
        begin
            if (board.owed.size() != 0)
                $display("%0t: %0d results never arrived", $time, board.owed.size());
            $display("** file_open_warrant_gate: FAILED **");
        end
        $finish;
    end
endmodule
